>>> hw/rtl/atrlc_pkg.sv
// ----------------------------------------------------------------------------
// AT response line classifier package
// Operation codes, keyword tables and flag positions shared by the classifier.
// ----------------------------------------------------------------------------
package atrlc_pkg;

	// Field widths of the stream items.
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 7;
	localparam int SRCH_W   = 3;
	localparam int MSG_BYTES = 7;
	localparam int MSG_W    = MSG_BYTES * BYTE_W;
	localparam int FLAG_W   = 6;
	localparam int OUT_W    = 64;

	// Line length limit and first captured byte of an IPD line.
	localparam int LINE_MAX       = 64;
	localparam int CAPTURE_OFFSET = 7;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_BYTE      = 2'd0;
	localparam logic [OP_W-1:0] OP_BURST_END = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR_ACK = 2'd2;
	localparam logic [OP_W-1:0] OP_TAKE_MSG  = 2'd3;

	// Characters with a special role.
	localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;

	// Sticky flag positions; keyword k sets flag bit k.
	localparam int FLAG_ACK     = 0;
	localparam int FLAG_ERROR   = 1;
	localparam int FLAG_WIFI    = 2;
	localparam int FLAG_ADDRESS = 3;
	localparam int FLAG_TCP     = 4;
	localparam int FLAG_PENDING = 5;

	// Exact-match keywords, in priority order: OK, ERROR, WIFI CONNECTED,
	// WIFI GOT IP, CONNECT. Text is right aligned, first character highest.
	localparam int KW_COUNT   = 5;
	localparam int KW_TEXT_MAX = 14;
	localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{7'd2, 7'd5, 7'd14, 7'd11, 7'd7};
	localparam logic [8*KW_TEXT_MAX-1:0] KW_TEXT [KW_COUNT] = '{
		"OK", "ERROR", "WIFI CONNECTED", "WIFI GOT IP", "CONNECT"
	};

	// IPD marker search.
	localparam int IPD_LEN = 5;
	localparam logic [SRCH_W-1:0] IPD_DEAD = 3'd7;

	typedef logic [FLAG_W-1:0] flags_t;

	// Character p of keyword k; only called with p below the keyword length.
	function automatic logic [BYTE_W-1:0] kw_char(input logic [2:0] k, input logic [3:0] p);
		int sel;
		sel = int'(KW_LEN[k]) - 1 - int'(p);
		if (sel < 0) begin
			sel = 0;
		end
		return KW_TEXT[k][8*sel +: 8];
	endfunction

	// Character i of the "+IPD," marker.
	function automatic logic [BYTE_W-1:0] ipd_char(input logic [SRCH_W-1:0] i);
		logic [BYTE_W-1:0] c;
		unique case (i)
			3'd0:    c = "+";
			3'd1:    c = "I";
			3'd2:    c = "P";
			3'd3:    c = "D";
			3'd4:    c = ",";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/at_response_line_classifier.sv
// ----------------------------------------------------------------------------
// AT response line classifier
// Splits received modem bytes into lines, recognizes status lines and captures
// the payload of IPD lines; every request returns all flags and the message.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bits first)
//  s_*      in         tuser: operation[1:0]; tdata: rx_byte[7:0]
//  m_*      out        tdata: ack_seen, error_seen, message_pending, wifi_connected,
//                      wifi_got_address, tcp_connected, wifi_confirmed,
//                      message[62:7], zero fill to 64 bits
//
// One request per cycle while the output register is empty or taken. A request
// is registered on input and classified against the line state; the result
// loads into the output register once that register can load, and is offered
// from there. The input stage holds only while the output register is full and
// not taken. arst_n clears the line state, the flags and the held message.

module at_response_line_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // operation[1:0]
	input  logic [7:0]  s_tdata,  // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // flags [6:0] (ack, error, pending, wifi,
	                              // address, tcp, confirmed), message [62:7], zero [63]
);

	// Input stage.
	logic                            valid_s1;
	logic [atrlc_pkg::OP_W-1:0]      op_s1;
	logic [atrlc_pkg::BYTE_W-1:0]    byte_s1;

	// Output stage.
	logic                            valid_s2;
	logic [atrlc_pkg::OUT_W-1:0]     res_s2;

	// Line and flag state.
	logic [atrlc_pkg::POS_W-1:0]     pos_q, pos_d;
	logic [atrlc_pkg::KW_COUNT-1:0]  alive_q, alive_d;
	logic [atrlc_pkg::SRCH_W-1:0]    search_q, search_d, search_step;
	logic                            found_q, found_d;
	logic [atrlc_pkg::MSG_W-1:0]     cap_q, cap_d;
	atrlc_pkg::flags_t               flags_q, flags_d;
	logic [atrlc_pkg::MSG_W-1:0]     held_q, held_d;

	logic                            advance;
	logic                            do_close;
	logic                            do_add;
	logic [atrlc_pkg::KW_COUNT-1:0]  kw_hit;
	logic                            confirmed_d;

	// Handshake: the input stage moves on when the output register can load.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Keyword hits at the end of the current line.
	always_comb begin
		for (int k = 0; k < atrlc_pkg::KW_COUNT; k++) begin
			kw_hit[k] = alive_q[k] && (pos_q == atrlc_pkg::KW_LEN[k]);
		end
	end

	// Request decode and next line state.
	always_comb begin
		pos_d       = pos_q;
		alive_d     = alive_q;
		search_d    = search_q;
		found_d     = found_q;
		cap_d       = cap_q;
		flags_d     = flags_q;
		held_d      = held_q;
		do_close    = 1'b0;
		do_add      = 1'b0;
		search_step = '0;

		unique case (op_s1)
			atrlc_pkg::OP_BYTE: begin
				if (byte_s1 == atrlc_pkg::CHAR_CR || byte_s1 == atrlc_pkg::CHAR_LF) begin
					do_close = 1'b1;
				end else begin
					do_add = 1'b1;
				end
			end
			atrlc_pkg::OP_BURST_END: begin
				do_close = 1'b1;
			end
			atrlc_pkg::OP_CLEAR_ACK: begin
				flags_d[atrlc_pkg::FLAG_ACK] = 1'b0;
			end
			atrlc_pkg::OP_TAKE_MSG: begin
				flags_d[atrlc_pkg::FLAG_PENDING] = 1'b0;
			end
			default: begin
			end
		endcase

		if (do_close) begin
			// Classify a live, nonempty line; the first match wins.
			if (search_q != atrlc_pkg::IPD_DEAD && pos_q != '0) begin
				if (kw_hit[0]) begin
					flags_d[atrlc_pkg::FLAG_ACK] = 1'b1;
				end else if (kw_hit[1]) begin
					flags_d[atrlc_pkg::FLAG_ERROR] = 1'b1;
				end else if (found_q) begin
					flags_d[atrlc_pkg::FLAG_PENDING] = 1'b1;
					held_d = cap_q;
				end else if (kw_hit[2]) begin
					flags_d[atrlc_pkg::FLAG_WIFI] = 1'b1;
				end else if (kw_hit[3]) begin
					flags_d[atrlc_pkg::FLAG_ADDRESS] = 1'b1;
				end else if (kw_hit[4]) begin
					flags_d[atrlc_pkg::FLAG_TCP] = 1'b1;
				end
			end
			pos_d    = '0;
			alive_d  = '1;
			search_d = '0;
			found_d  = 1'b0;
			cap_d    = '0;
		end else if (do_add && search_q != atrlc_pkg::IPD_DEAD) begin
			if (pos_q >= atrlc_pkg::POS_W'(atrlc_pkg::LINE_MAX)) begin
				// Overlong line: nothing matches until the next terminator.
				search_d = atrlc_pkg::IPD_DEAD;
				found_d  = 1'b0;
				alive_d  = '0;
			end else begin
				// Drop keywords that the new character no longer matches.
				for (int k = 0; k < atrlc_pkg::KW_COUNT; k++) begin
					if (alive_q[k] && (pos_q >= atrlc_pkg::KW_LEN[k] ||
					    byte_s1 != atrlc_pkg::kw_char(3'(k), pos_q[3:0]))) begin
						alive_d[k] = 1'b0;
					end
				end

				// Advance the marker search until the marker has been seen.
				if (!found_q) begin
					if (search_q < atrlc_pkg::SRCH_W'(atrlc_pkg::IPD_LEN) &&
					    byte_s1 == atrlc_pkg::ipd_char(search_q)) begin
						search_step = search_q + 3'd1;
					end else if (byte_s1 == atrlc_pkg::CHAR_PLUS) begin
						search_step = 3'd1;
					end else begin
						search_step = 3'd0;
					end
					search_d = search_step;
					if (search_step == atrlc_pkg::SRCH_W'(atrlc_pkg::IPD_LEN)) begin
						found_d = 1'b1;
					end
				end

				// Capture the message window of the line.
				for (int i = 0; i < atrlc_pkg::MSG_BYTES; i++) begin
					if (pos_q == atrlc_pkg::POS_W'(atrlc_pkg::CAPTURE_OFFSET + i)) begin
						cap_d[8*i +: 8] = byte_s1;
					end
				end

				pos_d = pos_q + 7'd1;
			end
		end
	end

	assign confirmed_d = flags_d[atrlc_pkg::FLAG_ACK] && flags_d[atrlc_pkg::FLAG_WIFI] &&
		flags_d[atrlc_pkg::FLAG_ADDRESS];

	// State update, once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			alive_q  <= '1;
			search_q <= '0;
			found_q  <= 1'b0;
			cap_q    <= '0;
			flags_q  <= '0;
			held_q   <= '0;
		end else if (advance) begin
			pos_q    <= pos_d;
			alive_q  <= alive_d;
			search_q <= search_d;
			found_q  <= found_d;
			cap_q    <= cap_d;
			flags_q  <= flags_d;
			held_q   <= held_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= {1'b0, held_d, confirmed_d,
				flags_d[atrlc_pkg::FLAG_TCP], flags_d[atrlc_pkg::FLAG_ADDRESS],
				flags_d[atrlc_pkg::FLAG_WIFI], flags_d[atrlc_pkg::FLAG_PENDING],
				flags_d[atrlc_pkg::FLAG_ERROR], flags_d[atrlc_pkg::FLAG_ACK]};
		end
	end

	// The input side only stalls behind a full, untaken output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// A dead line has no live keyword and no marker.
	a_dead_line: assert property (@(posedge clk) disable iff (!arst_n)
		(search_q == atrlc_pkg::IPD_DEAD) |-> (alive_q == '0 && !found_q))
		else $error("dead line still matching");

	// The line position never passes the line limit.
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= atrlc_pkg::POS_W'(atrlc_pkg::LINE_MAX))
		else $error("line position beyond limit");

	// A message becomes pending only by closing a line.
	a_pending_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flags_q[atrlc_pkg::FLAG_PENDING]) |-> $past(advance && do_close))
		else $error("message pending set without a line end");

endmodule

>>> test/at_response_line_classifier_tb.sv
// ----------------------------------------------------------------------------
// AT response line classifier testbench
// Streams modem bytes and control requests into the classifier with random
// gaps and output stalls. A line-state model predicts the flags and held
// message of every result, and each result is checked in order against it.
// ----------------------------------------------------------------------------
module at_response_line_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 290;

	// Flags in result bit order, plus the held message.
	typedef struct {
		logic [6:0]                  flags;
		logic [atrlc_pkg::MSG_W-1:0] message;
	} status_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;   // operation[1:0]
	logic [7:0]  s_tdata;   // rx_byte[7:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;   // ack, error, pending, wifi, address, tcp, confirmed,
	                        // message [62:7], zero [63]

	at_response_line_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	string kw_word [atrlc_pkg::KW_COUNT] = '{"OK", "ERROR", "WIFI CONNECTED", "WIFI GOT IP",
		"CONNECT"};
	string ipd_marker = "+IPD,";
	string flag_name [7] = '{"ack_seen", "error_seen", "message_pending", "wifi_connected",
		"wifi_got_address", "tcp_connected", "wifi_confirmed"};

	// Line tracking state of the model.
	logic [atrlc_pkg::POS_W-1:0]    ln_pos;
	logic [atrlc_pkg::KW_COUNT-1:0] kw_live;
	logic [atrlc_pkg::SRCH_W-1:0]   ipd_step;
	logic                           ipd_seen;
	logic [atrlc_pkg::MSG_W-1:0]    ln_capture;
	atrlc_pkg::flags_t              sticky;
	logic [atrlc_pkg::MSG_W-1:0]    held_msg;

	status_t     expected_status [$];
	logic [7:0]  line_bytes [$];
	int          requests_sent;
	int          results_checked;
	int          mismatches;
	int          status_lines;
	int          ipd_lines;
	int          overlong_lines;
	int          quiet_cycles;
	int          rx_hold;
	bit          no_idle_tx;
	bit          no_idle_rx;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Any character except the line terminators, mostly printable.
	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 3) == 0) begin
				c = 8'($urandom_range(0, 255));
			end else begin
				c = 8'($urandom_range(32, 126));
			end
		end while (c == atrlc_pkg::CHAR_CR || c == atrlc_pkg::CHAR_LF);
		return c;
	endfunction

	function automatic logic [atrlc_pkg::OP_W-1:0] side_op();
		return ($urandom_range(0, 1) == 0) ? atrlc_pkg::OP_CLEAR_ACK : atrlc_pkg::OP_TAKE_MSG;
	endfunction

	function automatic void restart_line();
		ln_pos = '0;
		kw_live = '1;
		ipd_step = '0;
		ipd_seen = 1'b0;
		ln_capture = '0;
	endfunction

	function automatic bit kw_complete(input int k);
		return kw_live[k] && int'(ln_pos) == kw_word[k].len();
	endfunction

	// A terminator classifies the line; only the first hit in priority order counts.
	function automatic void close_line();
		if (ipd_step == atrlc_pkg::IPD_DEAD) begin
			overlong_lines++;
		end else if (ln_pos != 0) begin
			if (kw_complete(0)) begin
				sticky[atrlc_pkg::FLAG_ACK] = 1'b1;
				status_lines++;
			end else if (kw_complete(1)) begin
				sticky[atrlc_pkg::FLAG_ERROR] = 1'b1;
				status_lines++;
			end else if (ipd_seen) begin
				sticky[atrlc_pkg::FLAG_PENDING] = 1'b1;
				held_msg = ln_capture;
				ipd_lines++;
			end else if (kw_complete(2)) begin
				sticky[atrlc_pkg::FLAG_WIFI] = 1'b1;
				status_lines++;
			end else if (kw_complete(3)) begin
				sticky[atrlc_pkg::FLAG_ADDRESS] = 1'b1;
				status_lines++;
			end else if (kw_complete(4)) begin
				sticky[atrlc_pkg::FLAG_TCP] = 1'b1;
				status_lines++;
			end
		end
		restart_line();
	endfunction

	// One ordinary character of the current line.
	function automatic void add_char(input logic [7:0] c);
		int idx;
		if (ipd_step == atrlc_pkg::IPD_DEAD) begin
			return;
		end
		// A character past the length limit kills the line until its terminator.
		if (int'(ln_pos) >= atrlc_pkg::LINE_MAX) begin
			ipd_step = atrlc_pkg::IPD_DEAD;
			ipd_seen = 1'b0;
			kw_live = '0;
			return;
		end
		for (int k = 0; k < atrlc_pkg::KW_COUNT; k++) begin
			if (kw_live[k] && (int'(ln_pos) >= kw_word[k].len() ||
					kw_word[k].getc(int'(ln_pos)) != c)) begin
				kw_live[k] = 1'b0;
			end
		end
		if (!ipd_seen) begin
			if (ipd_step < atrlc_pkg::IPD_LEN && ipd_marker.getc(int'(ipd_step)) == c) begin
				ipd_step = ipd_step + 1'b1;
			end else begin
				ipd_step = (c == atrlc_pkg::CHAR_PLUS) ? 3'd1 : 3'd0;
			end
			if (ipd_step == atrlc_pkg::IPD_LEN) begin
				ipd_seen = 1'b1;
			end
		end
		idx = int'(ln_pos) - atrlc_pkg::CAPTURE_OFFSET;
		if (idx >= 0 && idx < atrlc_pkg::MSG_BYTES) begin
			ln_capture[8*idx +: 8] = c;
		end
		ln_pos = ln_pos + 1'b1;
	endfunction

	// Updates the line state for one request and returns the status it reports.
	function automatic status_t predict_status(input logic [atrlc_pkg::OP_W-1:0] op,
			input logic [7:0] c);
		status_t s;
		case (op)
			atrlc_pkg::OP_BYTE: begin
				if (c == atrlc_pkg::CHAR_CR || c == atrlc_pkg::CHAR_LF) begin
					close_line();
				end else begin
					add_char(c);
				end
			end
			atrlc_pkg::OP_BURST_END: begin
				close_line();
			end
			atrlc_pkg::OP_CLEAR_ACK: begin
				sticky[atrlc_pkg::FLAG_ACK] = 1'b0;
			end
			default: begin
				sticky[atrlc_pkg::FLAG_PENDING] = 1'b0;
			end
		endcase
		s.flags = {sticky[atrlc_pkg::FLAG_ACK] & sticky[atrlc_pkg::FLAG_WIFI] &
			sticky[atrlc_pkg::FLAG_ADDRESS],
			sticky[atrlc_pkg::FLAG_TCP], sticky[atrlc_pkg::FLAG_ADDRESS],
			sticky[atrlc_pkg::FLAG_WIFI], sticky[atrlc_pkg::FLAG_PENDING],
			sticky[atrlc_pkg::FLAG_ERROR], sticky[atrlc_pkg::FLAG_ACK]};
		s.message = held_msg;
		return s;
	endfunction

	function automatic void report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("tb: mismatch in %s at result %0d: expected %0h, got %0h",
				field, results_checked, want, got);
		end
	endfunction

	// Sends one request; called and left at a falling edge.
	task automatic send_request(input logic [atrlc_pkg::OP_W-1:0] op, input logic [7:0] c);
		int gap;
		gap = no_idle_tx ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = c;
		do @(posedge clk); while (!s_tready);
		expected_status.push_back(predict_status(op, c));
		requests_sent++;
		@(negedge clk);
	endtask

	function automatic void put_text(input string t);
		for (int i = 0; i < t.len(); i++) begin
			line_bytes.push_back(t.getc(i));
		end
	endfunction

	function automatic void put_random(input int n);
		repeat (n) line_bytes.push_back(rand_char());
	endfunction

	// Sends the buffered line with a random terminator, now and then mixing in
	// flag requests.
	task automatic send_line(input bit mix_ops);
		int t;
		foreach (line_bytes[i]) begin
			if (mix_ops && $urandom_range(0, 24) == 0) begin
				send_request(side_op(), rand_char());
			end
			send_request(atrlc_pkg::OP_BYTE, line_bytes[i]);
		end
		line_bytes.delete();
		t = $urandom_range(0, 3);
		case (t)
			0: send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_CR);
			1: send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_LF);
			2: begin
				send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_CR);
				send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_LF);
			end
			default: send_request(atrlc_pkg::OP_BURST_END, 8'($urandom_range(0, 255)));
		endcase
		if (mix_ops && $urandom_range(0, 3) == 0) begin
			send_request(side_op(), 8'($urandom_range(0, 255)));
		end
	endtask

	// Builds one line of a randomly chosen kind in the line buffer.
	function automatic void build_line();
		int r;
		int k;
		int n;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, atrlc_pkg::KW_COUNT - 1);
		if (r < 30) begin
			put_text(kw_word[k]);
		end else if (r < 40) begin
			// A keyword with one flaw.
			put_text(kw_word[k]);
			case ($urandom_range(0, 3))
				0: void'(line_bytes.pop_back());
				1: line_bytes.push_back(rand_char());
				2: line_bytes[$urandom_range(0, line_bytes.size() - 1)] = rand_char();
				default: line_bytes.push_front(8'h20);
			endcase
		end else if (r < 65) begin
			put_random($urandom_range(0, 6));
			put_text(ipd_marker);
			put_random($urandom_range(0, 15));
		end else if (r < 75) begin
			// Broken or restarted markers.
			case ($urandom_range(0, 3))
				0: put_text("++IPD,");
				1: put_text("+IP+IPD,");
				2: put_text("+IPD");
				default: put_text("+I,D+");
			endcase
			put_random($urandom_range(0, 12));
		end else if (r < 92) begin
			put_random($urandom_range(1, 12));
		end else if (r < 96) begin
			// Lengths around the limit.
			n = $urandom_range(atrlc_pkg::LINE_MAX - 2, atrlc_pkg::LINE_MAX + 3);
			if ($urandom_range(0, 1) == 0) begin
				put_text(ipd_marker);
				n = n - atrlc_pkg::IPD_LEN;
			end
			put_random(n);
		end
	endfunction

	// Status lines, burst end, empty line, an IPD capture with extreme bytes,
	// and both flag requests.
	task automatic test_directed_lines();
		send_request(atrlc_pkg::OP_BYTE, "O");
		send_request(atrlc_pkg::OP_BYTE, "K");
		send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_CR);
		send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_LF);
		send_request(atrlc_pkg::OP_CLEAR_ACK, 8'hFF);
		put_text("ERROR");
		foreach (line_bytes[i]) send_request(atrlc_pkg::OP_BYTE, line_bytes[i]);
		line_bytes.delete();
		send_request(atrlc_pkg::OP_BURST_END, 8'hFF);
		put_text("+IPD,1:");
		line_bytes.push_back(8'h00);
		line_bytes.push_back(8'hFF);
		line_bytes.push_back("A");
		foreach (line_bytes[i]) send_request(atrlc_pkg::OP_BYTE, line_bytes[i]);
		line_bytes.delete();
		send_request(atrlc_pkg::OP_BYTE, atrlc_pkg::CHAR_CR);
		send_request(atrlc_pkg::OP_TAKE_MSG, 8'h00);
	endtask

	// All status keywords, ending with the acknowledge that confirms the link.
	task automatic test_status_keywords();
		for (int k = atrlc_pkg::KW_COUNT - 1; k >= 0; k--) begin
			put_text(kw_word[k]);
			send_line(1'b0);
		end
		send_request(atrlc_pkg::OP_CLEAR_ACK, 8'h00);
		put_text(kw_word[0]);
		send_line(1'b0);
	endtask

	// A line of exactly the limit still counts; one three bytes longer is killed.
	task automatic test_overlong_lines();
		put_text(ipd_marker);
		put_random(atrlc_pkg::LINE_MAX - atrlc_pkg::IPD_LEN);
		send_line(1'b0);
		put_text(ipd_marker);
		put_random(atrlc_pkg::LINE_MAX - atrlc_pkg::IPD_LEN + 3);
		send_line(1'b0);
		put_text(kw_word[1]);
		send_line(1'b0);
	endtask

	// The receiver holds off while the sender keeps offering requests.
	task automatic test_output_backpressure();
		no_idle_tx = 1'b1;
		rx_hold = 48;
		put_text("+IPD,0,12:backpressure");
		send_line(1'b0);
		no_idle_tx = 1'b0;
	endtask

	// Back-to-back traffic with no gaps on either side.
	task automatic test_streaming();
		no_idle_tx = 1'b1;
		no_idle_rx = 1'b1;
		repeat (6) begin
			build_line();
			send_line(1'b1);
		end
		no_idle_tx = 1'b0;
		no_idle_rx = 1'b0;
	endtask

	// Unstructured requests: any operation, any byte.
	task automatic test_random_noise();
		repeat (40) send_request(atrlc_pkg::OP_W'($urandom_range(0, 3)),
			8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed lines with random content.
	task automatic test_random_lines();
		int start;
		start = requests_sent;
		while (requests_sent - start < RANDOM_REQUESTS) begin
			build_line();
			send_line(1'b1);
		end
	endtask

	// Output ready: random stalls, plus a long hold-off on request.
	initial begin : drive_ready
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold != 0) begin
				m_tready = 1'b0;
				rx_hold--;
			end else if (stall != 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
				stall = no_idle_rx ? 0 : pick_gap();
			end
		end
	end

	// Each result is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected result", 64'h0, m_tdata);
			end else begin
				want = expected_status.pop_front();
				for (int i = 0; i < 7; i++) begin
					if (m_tdata[i] !== want.flags[i]) begin
						report_mismatch(flag_name[i], 64'(want.flags[i]), 64'(m_tdata[i]));
					end
				end
				if (m_tdata[62:7] !== want.message) begin
					report_mismatch("message", 64'(want.message), 64'(m_tdata[62:7]));
				end
				results_checked++;
			end
		end
	end

	// Ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Reset, the tests in turn, drain, verdict.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		sticky = '0;
		held_msg = '0;
		restart_line();
		quiet_cycles = 0;
		rx_hold = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_lines();
		test_status_keywords();
		test_overlong_lines();
		test_output_backpressure();
		test_streaming();
		test_random_noise();
		test_random_lines();

		s_tvalid = 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d requests sent, %0d results checked, %0d mismatches",
			requests_sent, results_checked, mismatches);
		$display("tb: lines classified: %0d status, %0d IPD, %0d overlong",
			status_lines, ipd_lines, overlong_lines);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/atrlc_pkg.sv
hw/rtl/at_response_line_classifier.sv
test/at_response_line_classifier_tb.sv
